/* hw/rtl/rbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pkg: shared types, constants and helper functions
// Register indexes, the configuration bundle, the queue entry and the
// fixed-point helpers used by the RGBA blend and scale datapath.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int unsigned REG_INDEX_W = 3;

  localparam logic [REG_INDEX_W-1:0] REG_SOURCE_WIDTH     = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_SOURCE_HEIGHT    = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_TARGET_WIDTH     = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_TARGET_HEIGHT    = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_BACKGROUND_COLOR = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = QUEUE_PTR_W + 1;

  localparam int unsigned QUOT_W = 16;
  localparam int unsigned STEP_W = $clog2(QUOT_W);

  // Reciprocals for the exact truncating divides by 31 and by 63.
  localparam logic [13:0] RECIP_31 = 14'd8457;
  localparam logic [14:0] RECIP_63 = 15'd16645;

  typedef struct packed {
    logic [15:0] src_w;
    logic [15:0] src_h;
    logic [15:0] dst_w;
    logic [15:0] dst_h;
    logic [15:0] bg;
  } cfg_t;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        frame_end;
  } queue_entry_t;

  // A size register of zero behaves as one.
  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // floor(c * 255 / 31) for a 5-bit channel.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] x;
    logic [26:0] p;
    x = {c, 8'd0} - 13'(c);
    p = 27'(x) * 27'(RECIP_31);
    return p[25:18];
  endfunction

  // floor(c * 255 / 63) for a 6-bit channel.
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] x;
    logic [28:0] p;
    x = {c, 8'd0} - 14'(c);
    p = 29'(x) * 29'(RECIP_63);
    return p[27:20];
  endfunction

  // floor(v / 255), exact for every v up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = 17'(v) + 17'd1 + 17'(v[15:8]);
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/rbs_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_if: pixel and result stream interfaces
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rbs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       frame_start;

  modport source (output valid, red, green, blue, alpha, frame_start, input ready);
  modport sink   (input valid, red, green, blue, alpha, frame_start, output ready);
endinterface

interface rbs_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] dest_x;
  logic [15:0] dest_y;
  logic [15:0] pixel_565;
  logic        frame_end;

  modport source (output valid, dest_x, dest_y, pixel_565, frame_end, input ready);
  modport sink   (input valid, dest_x, dest_y, pixel_565, frame_end, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rgba_blend_scale_to_rgb565.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_blend_scale_to_rgb565: RGBA pixel blender and nearest-neighbor scaler
// Pixels enter on the pixels channel in raster order, one beat each; a beat
// with frame_start set puts the position back to column 0, row 0. Each pixel
// leaves as one beat on the results channel carrying its destination column
// and row, the pixel blended over the background color as RGB565, and a
// frame_end flag on the last pixel of the source image.
// The intake side takes a beat whenever the two-entry work queue has room.
// The engine behind it handles one pixel at a time and maps its position
// into the target bitmap with a shift-and-subtract divide (one quotient bit
// per cycle, column and row in parallel). An overflowing quotient saturates
// to 65535 at once; when both do, the engine does not wait for the divide.
// A stalled sink holds the result in the output register; the engine and
// then the queue fill up and pixels.ready drops. Reset empties the queue,
// clears the position counters and loads the registers with their defaults
// (sizes one, black background). Registers are written through wr_en,
// wr_index and wr_data; the user must write them only while no pixel is in
// flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rgba_blend_scale_to_rgb565 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [rbs_pkg::REG_INDEX_W-1:0] wr_index,
  input  logic [15:0]                     wr_data,
  rbs_pixel_if.sink                       pixels,
  rbs_result_if.source                    results
);

  rbs_pkg::cfg_t         cfg;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  rbs_pkg::queue_entry_t q_in;
  rbs_pkg::queue_entry_t q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_w <= 16'd1;
      cfg.src_h <= 16'd1;
      cfg.dst_w <= 16'd1;
      cfg.dst_h <= 16'd1;
      cfg.bg    <= 16'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        rbs_pkg::REG_SOURCE_WIDTH:     cfg.src_w <= wr_data;
        rbs_pkg::REG_SOURCE_HEIGHT:    cfg.src_h <= wr_data;
        rbs_pkg::REG_TARGET_WIDTH:     cfg.dst_w <= wr_data;
        rbs_pkg::REG_TARGET_HEIGHT:    cfg.dst_h <= wr_data;
        rbs_pkg::REG_BACKGROUND_COLOR: cfg.bg    <= wr_data;
        default: ;
      endcase
    end
  end

  rbs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pixels (pixels),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  rbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  rbs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_out),
    .results (results)
  );

  // The engine never takes an entry from an empty queue.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A pixel pushed into an empty queue is visible to the engine next cycle.
  assert property (@(posedge clk) disable iff (rst) q_push && q_empty |=> !q_empty)
    else $error("pushed pixel lost");

  // Nothing is presented on the result channel right after reset.
  assert property (@(posedge clk) $past(rst) |-> !results.valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

/* hw/rtl/rbs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_front: pixel intake and position tracking
// Accepts pixels, assigns each its source column and row, flags the last
// pixel of the image and pushes the result into the work queue.
// ----------------------------------------------------------------------------
module rbs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  rbs_pkg::cfg_t        cfg,
  rbs_pixel_if.sink            pixels,
  input  logic                 q_full,
  output logic                 q_push,
  output rbs_pkg::queue_entry_t q_data
);

  logic [15:0] column_count;
  logic [15:0] row_count;
  logic [15:0] col_cur;
  logic [15:0] row_cur;
  logic [15:0] src_w;
  logic [15:0] src_h;
  logic        col_wrap;
  logic        row_wrap;

  assign pixels.ready = !q_full;
  assign q_push       = pixels.valid && !q_full;

  always_comb begin
    src_w    = rbs_pkg::at_least_one(cfg.src_w);
    src_h    = rbs_pkg::at_least_one(cfg.src_h);
    col_cur  = pixels.frame_start ? 16'd0 : column_count;
    row_cur  = pixels.frame_start ? 16'd0 : row_count;
    // Compare at 17 bits so a counter at 65535 still wraps.
    col_wrap = (17'(col_cur) + 17'd1) >= 17'(src_w);
    row_wrap = (17'(row_cur) + 17'd1) >= 17'(src_h);

    q_data.col       = col_cur;
    q_data.row       = row_cur;
    q_data.red       = pixels.red;
    q_data.green     = pixels.green;
    q_data.blue      = pixels.blue;
    q_data.alpha     = pixels.alpha;
    q_data.frame_end = col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 16'd0;
      row_count    <= 16'd0;
    end else if (q_push) begin
      if (col_wrap) begin
        column_count <= 16'd0;
        row_count    <= row_wrap ? 16'd0 : row_cur + 16'd1;
      end else begin
        column_count <= col_cur + 16'd1;
        row_count    <= row_cur;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rbs_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_queue: short work queue between front and back
// A small first-in first-out buffer of pixels tagged with their positions.
// ----------------------------------------------------------------------------
module rbs_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rbs_pkg::queue_entry_t push_data,
  input  logic                  pop,
  output rbs_pkg::queue_entry_t pop_data,
  output logic                  full,
  output logic                  empty
);

  rbs_pkg::queue_entry_t                 slots [rbs_pkg::QUEUE_DEPTH];
  logic [rbs_pkg::QUEUE_PTR_W-1:0]       wr_ptr;
  logic [rbs_pkg::QUEUE_PTR_W-1:0]       rd_ptr;
  logic [rbs_pkg::QUEUE_CNT_W-1:0]       count;

  localparam logic [rbs_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    rbs_pkg::QUEUE_PTR_W'(rbs_pkg::QUEUE_DEPTH - 1);

  assign full     = (count == rbs_pkg::QUEUE_CNT_W'(rbs_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rbs_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_divider: saturating 32 by 16 bit restoring divider
// Produces floor(dividend / divisor) clamped to 16 bits, one quotient bit
// per cycle; an overflowing quotient is settled in the start cycle.
// ----------------------------------------------------------------------------
module rbs_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] quotient
);

  logic [15:0]                 rem;
  logic [15:0]                 quo;
  logic [15:0]                 div_reg;
  logic [rbs_pkg::STEP_W-1:0]  step;
  logic [16:0]                 trial;
  logic                        fits;
  logic                        sat;

  // The quotient exceeds 16 bits exactly when the high half reaches the divisor.
  assign sat      = dividend[31:16] >= divisor;
  assign trial    = {rem, quo[15]};
  assign fits     = trial >= 17'(div_reg);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !sat;
    end else if (busy && step == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= dividend[31:16];
      quo     <= sat ? 16'hFFFF : dividend[15:0];
      div_reg <= divisor;
      step    <= rbs_pkg::STEP_W'(rbs_pkg::QUOT_W - 1);
    end else if (busy) begin
      rem  <= fits ? 16'(trial - 17'(div_reg)) : trial[15:0];
      quo  <= {quo[14:0], fits};
      step <= step - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rbs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_back: blend and coordinate scaling engine
// Takes one queued pixel at a time, blends it over the background, scales
// its position into the target bitmap and holds the result for the sink.
// ----------------------------------------------------------------------------
module rbs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rbs_pkg::cfg_t         cfg,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  rbs_pkg::queue_entry_t q_data,
  rbs_result_if.source          results
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]            state;
  logic [2:0]            state_next;
  rbs_pkg::queue_entry_t item;
  logic [31:0]           prod_x;
  logic [31:0]           prod_y;
  logic [15:0]           sum_r;
  logic [15:0]           sum_g;
  logic [15:0]           sum_b;
  logic [7:0]            bg_r;
  logic [7:0]            bg_g;
  logic [7:0]            bg_b;
  logic [7:0]            inv_alpha;
  logic [7:0]            blend_r;
  logic [7:0]            blend_g;
  logic [7:0]            blend_b;
  logic [15:0]           pix;
  logic                  div_start;
  logic                  busy_x;
  logic                  busy_y;
  logic [15:0]           quot_x;
  logic [15:0]           quot_y;
  logic                  out_valid;
  logic                  out_load;
  logic [15:0]           out_x;
  logic [15:0]           out_y;
  logic [15:0]           out_pix;
  logic                  out_end;

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign div_start = (state == ST_START);
  assign out_load  = (state == ST_OUT) && (!out_valid || results.ready);
  assign inv_alpha = 8'd255 - item.alpha;
  assign blend_r   = rbs_pkg::div255(sum_r);
  assign blend_g   = rbs_pkg::div255(sum_g);
  assign blend_b   = rbs_pkg::div255(sum_b);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!q_empty) state_next = ST_MUL;
      ST_MUL:   state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (!busy_x && !busy_y) state_next = ST_OUT;
      ST_OUT:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Background expansion depends only on configuration, so it is simply
  // re-registered every cycle.
  always_ff @(posedge clk) begin
    bg_r <= rbs_pkg::expand5(cfg.bg[15:11]);
    bg_g <= rbs_pkg::expand6(cfg.bg[10:5]);
    bg_b <= rbs_pkg::expand5(cfg.bg[4:0]);

    if (q_pop) begin
      item <= q_data;
    end
    if (state == ST_MUL) begin
      prod_x <= 32'(item.col) * 32'(rbs_pkg::at_least_one(cfg.dst_w));
      prod_y <= 32'(item.row) * 32'(rbs_pkg::at_least_one(cfg.dst_h));
      sum_r  <= 16'(item.red) * 16'(item.alpha) + 16'(bg_r) * 16'(inv_alpha);
      sum_g  <= 16'(item.green) * 16'(item.alpha) + 16'(bg_g) * 16'(inv_alpha);
      sum_b  <= 16'(item.blue) * 16'(item.alpha) + 16'(bg_b) * 16'(inv_alpha);
    end
    if (state == ST_START) begin
      pix <= {blend_r[7:3], blend_g[7:2], blend_b[7:3]};
    end
    if (out_load) begin
      out_x   <= quot_x;
      out_y   <= quot_y;
      out_pix <= pix;
      out_end <= item.frame_end;
    end
  end

  rbs_divider u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_x),
    .divisor  (rbs_pkg::at_least_one(cfg.src_w)),
    .busy     (busy_x),
    .quotient (quot_x)
  );

  rbs_divider u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_y),
    .divisor  (rbs_pkg::at_least_one(cfg.src_h)),
    .busy     (busy_y),
    .quotient (quot_y)
  );

  assign results.valid     = out_valid;
  assign results.dest_x    = out_x;
  assign results.dest_y    = out_y;
  assign results.pixel_565 = out_pix;
  assign results.frame_end = out_end;

endmodule
`default_nettype wire

/* bench/rgba_blend_scale_to_rgb565_tb.sv */
// ----------------------------------------------------------------------------
// rgba_blend_scale_to_rgb565_tb: self-checking bench for the blend and scaler
// Drives RGBA pixel beats into the block and predicts every result beat:
// the nearest-neighbor destination column and row, the pixel blended over
// the RGB565 background and repacked, and the end-of-frame flag. Directed
// cases cover the channel and alpha extremes, frame restarts, zero sizes and
// sizes shrunk mid-frame, then random frames run under several register
// settings, with random stalls on both channels in part of them.
// ----------------------------------------------------------------------------
module rgba_blend_scale_to_rgb565_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_start;
  } px_beat_t;

  typedef struct packed {
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [15:0] pixel_565;
    logic        frame_end;
  } res_beat_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            wr_en;
  logic [rbs_pkg::REG_INDEX_W-1:0] wr_index;
  logic [15:0]                     wr_data;

  rbs_pixel_if  pix_if ();
  rbs_result_if res_if ();

  rgba_blend_scale_to_rgb565 u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pixels   (pix_if),
    .results  (res_if)
  );

  always #6 clk = ~clk;

  // Shadow of the block's registers and position counters.
  rbs_pkg::cfg_t cfg_shadow;
  int unsigned   col_pos;
  int unsigned   row_pos;

  res_beat_t   pending_results[$];
  int unsigned pixels_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;
  bit          bursts_on    = 1'b1;

  function automatic int unsigned size_or_one(logic [15:0] v);
    return (v == 16'd0) ? 1 : int'(v);
  endfunction

  function automatic int unsigned mix_channel(int unsigned fg, int unsigned bgc,
                                              int unsigned a);
    return (fg * a + bgc * (255 - a)) / 255;
  endfunction

  function automatic logic [15:0] map_coord(int unsigned pos, logic [15:0] dst,
                                            int unsigned src);
    longint unsigned q;
    q = pos;
    q = q * size_or_one(dst);
    q = q / src;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Expected result of one pixel beat; advances the shadow position.
  function automatic res_beat_t blend_and_map(px_beat_t p);
    res_beat_t   r;
    int unsigned sw, sh, bg_r, bg_g, bg_b, o_r, o_g, o_b;
    bit          col_wrap, row_wrap;
    sw = size_or_one(cfg_shadow.src_w);
    sh = size_or_one(cfg_shadow.src_h);
    if (p.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    bg_r = cfg_shadow.bg[15:11];
    bg_g = cfg_shadow.bg[10:5];
    bg_b = cfg_shadow.bg[4:0];
    bg_r = bg_r * 255 / 31;
    bg_g = bg_g * 255 / 63;
    bg_b = bg_b * 255 / 31;
    o_r = mix_channel(p.red, bg_r, p.alpha);
    o_g = mix_channel(p.green, bg_g, p.alpha);
    o_b = mix_channel(p.blue, bg_b, p.alpha);
    col_wrap = (col_pos + 1 >= sw);
    row_wrap = (row_pos + 1 >= sh);
    r.dest_x    = map_coord(col_pos, cfg_shadow.dst_w, sw);
    r.dest_y    = map_coord(row_pos, cfg_shadow.dst_h, sh);
    r.pixel_565 = {o_r[7:3], o_g[7:2], o_b[7:3]};
    r.frame_end = col_wrap && row_wrap;
    if (col_wrap) begin
      col_pos = 0;
      row_pos = row_wrap ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = (col_pos + 1) & 32'hFFFF;
    end
    return r;
  endfunction

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  // Result checking first, then register and pixel tracking, all on the
  // values sampled just before the edge.
  always @(posedge clk) begin
    res_beat_t got, want;
    px_beat_t  beat;
    if (rst) begin
      cfg_shadow = '{src_w: 16'd1, src_h: 16'd1, dst_w: 16'd1, dst_h: 16'd1,
                     bg: 16'd0};
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.dest_x, res_if.dest_y, res_if.pixel_565, res_if.frame_end};
        results_seen++;
        if (pending_results.size() == 0) begin
          note_error($sformatf("unexpected result beat x=%0d y=%0d pix=%h end=%b",
                               got.dest_x, got.dest_y, got.pixel_565, got.frame_end));
        end else begin
          want = pending_results.pop_front();
          if (got.dest_x !== want.dest_x || got.dest_y !== want.dest_y ||
              got.pixel_565 !== want.pixel_565 || got.frame_end !== want.frame_end) begin
            note_error($sformatf(
              "mismatch: exp x=%0d y=%0d pix=%h end=%b, got x=%0d y=%0d pix=%h end=%b",
              want.dest_x, want.dest_y, want.pixel_565, want.frame_end,
              got.dest_x, got.dest_y, got.pixel_565, got.frame_end));
          end
        end
      end
      if (wr_en) begin
        case (wr_index)
          rbs_pkg::REG_SOURCE_WIDTH:     cfg_shadow.src_w = wr_data;
          rbs_pkg::REG_SOURCE_HEIGHT:    cfg_shadow.src_h = wr_data;
          rbs_pkg::REG_TARGET_WIDTH:     cfg_shadow.dst_w = wr_data;
          rbs_pkg::REG_TARGET_HEIGHT:    cfg_shadow.dst_h = wr_data;
          rbs_pkg::REG_BACKGROUND_COLOR: cfg_shadow.bg    = wr_data;
          default: ;
        endcase
      end
      if (pix_if.valid && pix_if.ready) begin
        beat = '{pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha, pix_if.frame_start};
        pending_results.push_back(blend_and_map(beat));
      end
    end
  end

  // Result sink with random stall bursts.
  initial begin : sink_stalls
    int unsigned hold;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 14);
        res_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Called at a clock edge; returns at the edge where the beat is taken.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a, logic fs);
    int unsigned gap;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.red         <= r;
    pix_if.green       <= g;
    pix_if.blue        <= b;
    pix_if.alpha       <= a;
    pix_if.frame_start <= fs;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
  endtask

  // Drain: stop sending, wait for every result, then let the engine go quiet.
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (results_seen < pixels_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rbs_pkg::REG_INDEX_W-1:0] idx, logic [15:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_sizes(logic [15:0] sw, logic [15:0] sh, logic [15:0] tw,
                             logic [15:0] th, logic [15:0] bgc);
    write_reg(rbs_pkg::REG_SOURCE_WIDTH, sw);
    write_reg(rbs_pkg::REG_SOURCE_HEIGHT, sh);
    write_reg(rbs_pkg::REG_TARGET_WIDTH, tw);
    write_reg(rbs_pkg::REG_TARGET_HEIGHT, th);
    write_reg(rbs_pkg::REG_BACKGROUND_COLOR, bgc);
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_src_size(int unsigned max_len);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'(max_len);
      default: return 16'($urandom_range(2, max_len));
    endcase
  endfunction

  function automatic logic [15:0] pick_dst_size();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [15:0] pick_background();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Registers at their reset values: every pixel is a whole frame.
  task automatic test_reset_defaults();
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd128, 8'd64, 8'd200, 8'd127, 1'b0);
    settle();
  endtask

  // Alpha and channel extremes over a white background, then a restart
  // in the middle of a frame.
  task automatic test_blend_extremes();
    write_sizes(16'd4, 16'd2, 16'd7, 16'd3, 16'hFFFF);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd1, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd254, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd128, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50, 8'd127, 1'b0);
    send_pixel(8'd17, 8'd34, 8'd51, 8'd64, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd1, 8'd2, 8'd3, 8'd200, 1'b0);
    send_pixel(8'd4, 8'd5, 8'd6, 8'd100, 1'b1);
    settle();
  endtask

  // Size registers of zero act as one.
  task automatic test_zero_sizes();
    write_sizes(16'd0, 16'd0, 16'd0, 16'd0, 16'hF81F);
    send_pixel(8'd90, 8'd180, 8'd30, 8'd77, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd128, 8'd200, 1'b0);
    settle();
  endtask

  // Sizes shrunk below the counters mid-frame; quotients saturate.
  task automatic test_shrink_saturate();
    write_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h07E0);
    send_pixel(8'd10, 8'd20, 8'd30, 8'd40, 1'b1);
    send_pixel(8'd50, 8'd60, 8'd70, 8'd80, 1'b0);
    send_pixel(8'd90, 8'd100, 8'd110, 8'd120, 1'b0);
    send_pixel(8'd130, 8'd140, 8'd150, 8'd160, 1'b0);
    settle();
    write_reg(rbs_pkg::REG_SOURCE_WIDTH, 16'd1);
    send_pixel(8'd170, 8'd180, 8'd190, 8'd0, 1'b0);
    send_pixel(8'd210, 8'd220, 8'd230, 8'd255, 1'b0);
    settle();
    write_reg(rbs_pkg::REG_SOURCE_HEIGHT, 16'd1);
    send_pixel(8'd255, 8'd128, 8'd0, 8'd33, 1'b0);
    settle();
  endtask

  // Random settings, mostly whole frames, with partial frames, stray
  // restarts and mid-frame shrinks mixed in.
  task automatic test_random_traffic(int unsigned stop_at, bit allow_bursts);
    logic [15:0] sw, sh, tw, th, bgc;
    int unsigned frame_len, len, k;
    while (pixels_sent < stop_at) begin
      settle();
      sw  = pick_src_size(12);
      sh  = pick_src_size(6);
      tw  = pick_dst_size();
      th  = pick_dst_size();
      bgc = pick_background();
      write_sizes(sw, sh, tw, th, bgc);
      bursts_on = allow_bursts && ($urandom_range(0, 3) != 0);
      frame_len = size_or_one(sw) * size_or_one(sh);
      repeat ($urandom_range(1, 3)) begin
        len = frame_len;
        if (len > 64 || $urandom_range(0, 5) == 0) begin
          len = $urandom_range(1, (len > 64) ? 64 : len);
        end
        for (k = 0; k < len; k++) begin
          send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                     (k == 0) || ($urandom_range(0, 59) == 0));
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        settle();
        write_reg(rbs_pkg::REG_SOURCE_WIDTH, 16'($urandom_range(0, 2)));
        if ($urandom_range(0, 1) == 0) begin
          write_reg(rbs_pkg::REG_SOURCE_HEIGHT, 16'($urandom_range(0, 2)));
        end
        repeat ($urandom_range(1, 5)) begin
          send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), 1'b0);
        end
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = rbs_pkg::REG_SOURCE_WIDTH;
    wr_data            = 16'd0;
    pix_if.valid       = 1'b0;
    pix_if.red         = 8'd0;
    pix_if.green       = 8'd0;
    pix_if.blue        = 8'd0;
    pix_if.alpha       = 8'd0;
    pix_if.frame_start = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_blend_extremes();
    test_zero_sizes();
    test_shrink_saturate();
    test_random_traffic(pixels_sent + 1450, 1'b1);
    bursts_on = 1'b0;
    test_random_traffic(pixels_sent + 200, 1'b0);

    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_if.sv
hw/rtl/rbs_front.sv
hw/rtl/rbs_queue.sv
hw/rtl/rbs_divider.sv
hw/rtl/rbs_back.sv
hw/rtl/rgba_blend_scale_to_rgb565.sv
bench/rgba_blend_scale_to_rgb565_tb.sv
